>>> hw/rtl/bbi2c_pkg.sv
// package: request codes, field widths and channel payload types
`default_nettype none
package bbi2c_pkg;
    localparam int BufDepth = 32;
    localparam int MaxMsgs = 2;

    localparam logic [2:0] REQ_TICK = 3'd0;
    localparam logic [2:0] REQ_DESC = 3'd1;
    localparam logic [2:0] REQ_LOAD = 3'd2;
    localparam logic [2:0] REQ_START = 3'd3;
    localparam logic [2:0] REQ_ACK = 3'd4;
    localparam logic [2:0] REQ_CANCEL = 3'd5;

    localparam logic [1:0] RES_OK = 2'd0;
    localparam logic [1:0] RES_NACK = 2'd1;
    localparam logic [1:0] RES_REJECT = 2'd2;

    localparam logic CFG_WAIT_WR = 1'b0;
    localparam logic CFG_WAIT_RD = 1'b1;

    typedef struct packed {
        logic [2:0] req_type;
        logic       sda_in;
        logic       msg_index;
        logic [6:0] dev_addr;
        logic       read_flag;
        logic [5:0] msg_length;
        logic [1:0] num_msgs;
        logic [4:0] buf_index;
        logic [7:0] byte_value;
    } t_req;

    typedef struct packed {
        logic       scl_level;
        logic       sda_drive;
        logic       sda_level;
        logic       status_level;
        logic       busy_res;
        logic       done_res;
        logic [1:0] result_code;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       rx_msg_index;
        logic [4:0] rx_buf_index;
        logic       timer_stop;
    } t_res;

    // buffer memory access from the sequencer
    typedef struct packed {
        logic       we;
        logic [5:0] waddr;
        logic [7:0] wdata;
        logic [5:0] raddr;
    } t_mem_req;
endpackage
`default_nettype wire

>>> hw/rtl/bbi2c_req_if.sv
// valid/ready channel interfaces for request and result words
`default_nettype none
interface bbi2c_req_if;
    logic valid;
    logic ready;
    bbi2c_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bbi2c_res_if;
    logic valid;
    logic ready;
    bbi2c_pkg::t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/bitbang_i2c_master.sv
// top level: bit-banged i2c master sequencer with buffer memory
// One request word is accepted per clock, and each produces one result word
// that sits in an output register until taken; a new word is accepted when that
// register is empty or being taken the same cycle. A write-data byte is read
// from the buffer memory ahead of its use, while the wait phase before it runs,
// so the memory's registered read never stalls the tick rate. Received bytes
// are written back to the buffer and also reported on the result word.
`default_nettype none
module bitbang_i2c_master (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_index,
    input  wire logic [3:0] i_cfg_data,
    bbi2c_req_if.sink       i_req,
    bbi2c_res_if.source     o_res
);
    typedef enum logic [3:0] {
        PH_IDLE, PH_START, PH_START2, PH_ADDR, PH_WRITE, PH_READ, PH_WBIT,
        PH_RBIT, PH_WACK, PH_RACK, PH_STOP, PH_STOP2, PH_STOP3, PH_RESTART,
        PH_WAIT, PH_COMPLETE
    } t_phase;

    t_phase r_phase, n_phase;
    logic r_clk_ph, n_clk_ph, r_nack, n_nack, r_cur, n_cur, r_err, n_err;
    logic [1:0] r_cnt, n_cnt;
    logic [7:0] r_bsel, n_bsel, r_shift, n_shift;
    logic [5:0] r_off, n_off;
    logic [3:0] r_wcnt, n_wcnt, r_wwr, r_wrd;
    logic r_stat, n_stat, r_sdrv, n_sdrv, r_slvl, n_slvl, r_scl, n_scl;
    logic [6:0] r_addr [bbi2c_pkg::MaxMsgs];
    logic r_isrd [bbi2c_pkg::MaxMsgs];
    logic [5:0] r_len [bbi2c_pkg::MaxMsgs];
    logic r_ovalid;
    bbi2c_pkg::t_res r_odata, n_res;
    bbi2c_pkg::t_mem_req mreq;
    logic [7:0] rdata;
    logic take;
    bbi2c_pkg::t_req q;

    bbi2c_buf_ram u_ram (.i_clk(i_clk), .i_req(mreq), .o_rdata(rdata));

    assign i_req.ready = !r_ovalid || o_res.ready;
    assign take = i_req.valid && i_req.ready;
    assign q = i_req.data;
    assign o_res.valid = r_ovalid;
    assign o_res.data = r_odata;

    always_comb begin
        logic [5:0] mlen;
        logic [7:0] sh;
        logic [7:0] bs;
        logic wb_done;
        mlen = r_len[r_cur];
        n_phase = r_phase; n_clk_ph = r_clk_ph; n_nack = r_nack; n_cur = r_cur;
        n_err = r_err; n_cnt = r_cnt; n_bsel = r_bsel; n_shift = r_shift;
        n_off = r_off; n_wcnt = r_wcnt; n_stat = r_stat; n_sdrv = r_sdrv;
        n_slvl = r_slvl; n_scl = r_scl;
        n_res = '0;
        sh = r_shift; bs = r_bsel; wb_done = 1'b0;
        // prefetch the next write byte
        mreq.raddr = {r_cur, r_off[4:0]};
        mreq.we = 1'b0;
        mreq.waddr = {q.msg_index, q.buf_index};
        mreq.wdata = q.byte_value;
        unique case (q.req_type)
            bbi2c_pkg::REQ_TICK: begin
                n_scl = r_clk_ph;
                unique case (r_phase)
                    PH_START: begin
                        n_cur = 1'b0; n_err = 1'b0; n_phase = PH_START2;
                    end
                    PH_START2: begin
                        n_sdrv = 1'b1; n_slvl = 1'b0; n_clk_ph = 1'b0;
                        n_nack = 1'b0; n_phase = PH_ADDR;
                    end
                    PH_ADDR, PH_WRITE, PH_WBIT: begin
                        if (r_phase == PH_ADDR) begin
                            sh = {r_addr[r_cur], r_isrd[r_cur]};
                            n_off = '0; bs = 8'h80;
                        end else if (r_phase == PH_WRITE) begin
                            sh = rdata; n_off = r_off + 6'd1; bs = 8'h80;
                        end
                        n_phase = PH_WBIT;
                        if (!r_clk_ph) begin
                            n_sdrv = 1'b1; n_slvl = |(sh & bs);
                            bs = bs >> 1;
                        end
                        if (bs == '0 && r_clk_ph) n_phase = PH_RACK;
                        n_clk_ph = !r_clk_ph;
                        n_shift = sh; n_bsel = bs;
                    end
                    PH_READ, PH_RBIT: begin
                        if (r_phase == PH_READ) begin
                            n_sdrv = 1'b0; n_phase = PH_RBIT; bs = 8'h80; sh = '0;
                        end
                        if (r_clk_ph) begin
                            if (q.sda_in) sh = sh | bs;
                            bs = bs >> 1;
                            wb_done = (bs == '0);
                        end
                        if (wb_done) begin
                            mreq.we = 1'b1;
                            mreq.waddr = {r_cur, r_off[4:0]};
                            mreq.wdata = sh;
                            n_res.rx_valid = 1'b1;
                            n_res.rx_byte = sh;
                            n_res.rx_msg_index = r_cur;
                            n_res.rx_buf_index = r_off[4:0];
                            n_off = r_off + 6'd1;
                            n_phase = PH_WACK;
                        end
                        n_clk_ph = !r_clk_ph;
                        n_shift = sh; n_bsel = bs;
                    end
                    PH_RACK: begin
                        if (!r_clk_ph) n_sdrv = 1'b0;
                        else if (!q.sda_in) begin
                            if (r_off < mlen) begin
                                n_wcnt = r_wwr; n_phase = PH_WAIT;
                            end else n_phase = PH_STOP;
                        end else begin
                            n_nack = 1'b1; n_err = 1'b1; n_phase = PH_STOP;
                        end
                        n_clk_ph = !r_clk_ph;
                    end
                    PH_WACK: begin
                        if (!r_clk_ph) begin
                            n_sdrv = 1'b1; n_slvl = (r_off == mlen);
                        end else if (r_off < mlen) begin
                            n_wcnt = r_wrd; n_phase = PH_WAIT;
                        end else n_phase = PH_STOP;
                        n_clk_ph = !r_clk_ph;
                    end
                    PH_WAIT: begin
                        if (r_wcnt != '0) n_wcnt = r_wcnt - 4'd1;
                        else n_phase = r_isrd[r_cur] ? PH_READ : PH_WRITE;
                    end
                    PH_STOP: begin
                        n_sdrv = 1'b1; n_slvl = 1'b0;
                        if (r_clk_ph) n_phase = PH_STOP2;
                        n_clk_ph = 1'b1;
                    end
                    PH_STOP2: begin
                        if ({1'b0, r_cur} + 2'd1 < r_cnt && !r_nack) begin
                            n_sdrv = 1'b1; n_slvl = 1'b1; n_clk_ph = !r_clk_ph;
                            if (!r_clk_ph) begin
                                n_cur = !r_cur; n_phase = PH_RESTART;
                            end
                        end else n_phase = PH_STOP3;
                    end
                    PH_RESTART: n_phase = PH_START2;
                    PH_STOP3: begin
                        n_sdrv = 1'b0; n_phase = PH_COMPLETE; n_stat = !r_stat;
                    end
                    PH_COMPLETE: n_stat = !r_stat;
                    default: n_res.timer_stop = 1'b1;
                endcase
            end
            bbi2c_pkg::REQ_LOAD: mreq.we = (r_phase == PH_IDLE);
            bbi2c_pkg::REQ_START: begin
                if (r_phase != PH_IDLE || q.num_msgs == 2'd0
                        || q.num_msgs > 2'(bbi2c_pkg::MaxMsgs))
                    n_res.result_code = bbi2c_pkg::RES_REJECT;
                else begin
                    n_cnt = q.num_msgs; n_phase = PH_START;
                end
            end
            bbi2c_pkg::REQ_ACK: begin
                if (r_phase == PH_COMPLETE) begin
                    n_stat = 1'b0; n_phase = PH_IDLE;
                end
            end
            bbi2c_pkg::REQ_CANCEL: n_phase = PH_IDLE;
            default: ;
        endcase
        mreq.we = mreq.we && take;
        n_res.scl_level = n_scl;
        n_res.sda_drive = n_sdrv;
        n_res.sda_level = n_slvl;
        n_res.status_level = n_stat;
        n_res.busy_res = (n_phase != PH_IDLE);
        n_res.done_res = (n_phase == PH_COMPLETE);
        if (n_res.result_code != bbi2c_pkg::RES_REJECT)
            n_res.result_code = n_err ? bbi2c_pkg::RES_NACK : bbi2c_pkg::RES_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_clk_ph <= 1'b1; r_nack <= 1'b0; r_cur <= 1'b0;
            r_err <= 1'b0; r_cnt <= '0; r_bsel <= '0; r_shift <= '0; r_off <= '0;
            r_wcnt <= '0; r_stat <= 1'b0; r_sdrv <= 1'b0; r_slvl <= 1'b1;
            r_scl <= 1'b1; r_wwr <= 4'd4; r_wrd <= 4'd2; r_ovalid <= 1'b0;
            r_addr[0] <= '0; r_addr[1] <= '0; r_isrd[0] <= 1'b0; r_isrd[1] <= 1'b0;
            r_len[0] <= '0; r_len[1] <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == bbi2c_pkg::CFG_WAIT_WR) r_wwr <= i_cfg_data;
                else r_wrd <= i_cfg_data;
            end
            if (take) begin
                r_phase <= n_phase; r_clk_ph <= n_clk_ph; r_nack <= n_nack;
                r_cur <= n_cur; r_err <= n_err; r_cnt <= n_cnt; r_bsel <= n_bsel;
                r_shift <= n_shift; r_off <= n_off; r_wcnt <= n_wcnt;
                r_stat <= n_stat; r_sdrv <= n_sdrv; r_slvl <= n_slvl; r_scl <= n_scl;
                r_odata <= n_res;
                if (q.req_type == bbi2c_pkg::REQ_DESC && r_phase == PH_IDLE) begin
                    r_addr[q.msg_index] <= q.dev_addr;
                    r_isrd[q.msg_index] <= q.read_flag;
                    r_len[q.msg_index] <= (q.msg_length > 6'(bbi2c_pkg::BufDepth))
                        ? 6'(bbi2c_pkg::BufDepth) : q.msg_length;
                end
            end
            r_ovalid <= take || (r_ovalid && !o_res.ready);
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !o_res.ready |=> $stable(r_odata))
        else $error("result changed while stalled");
    a_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_odata.rx_valid |-> r_odata.busy_res)
        else $error("rx byte outside transfer");
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_odata.timer_stop |-> !r_odata.busy_res)
        else $error("timer stop while busy");
endmodule
`default_nettype wire

>>> hw/rtl/bbi2c_buf_ram.sv
// message byte buffer, one write and one registered read port
`default_nettype none
module bbi2c_buf_ram (
    input  wire logic                  i_clk,
    input  wire bbi2c_pkg::t_mem_req   i_req,
    output logic [7:0]                 o_rdata
);
    logic [7:0] r_mem [bbi2c_pkg::MaxMsgs * bbi2c_pkg::BufDepth];
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end
endmodule
`default_nettype wire
